// File: sv/srm_pkg.sv
// Package for the sensor range monitor register block.
// Holds register map indexes, reset values and shared types; no dependencies.
package srm_pkg;

  localparam int NUM_SENSORS = 8;
  localparam int SENS_W = 3;

  localparam logic [5:0] IDX_CTRL0 = 6'd0;
  localparam logic [5:0] IDX_CTRL1 = 6'd1;
  localparam logic [5:0] IDX_CAL0 = 6'd2;
  localparam logic [5:0] IDX_CAL1 = 6'd3;
  localparam logic [5:0] IDX_TRNG0 = 6'd4;
  localparam logic [5:0] IDX_TRNG7 = 6'd11;
  localparam logic [5:0] IDX_VRNG0 = 6'd12;
  localparam logic [5:0] IDX_VRNG7 = 6'd19;
  localparam logic [5:0] IDX_RRNG7 = 6'd27;
  localparam logic [5:0] IDX_STAT_LO = 6'd28;
  localparam logic [5:0] IDX_ADC = 6'd36;
  localparam logic [5:0] IDX_THC0 = 6'd37;
  localparam logic [5:0] IDX_THC1 = 6'd38;
  localparam logic [5:0] IDX_LAST = 6'd38;

  localparam logic [31:0] RST_CTRL1 = 32'hFF00003F;
  localparam logic [31:0] RST_CAL0 = 32'h028B0537;
  localparam logic [31:0] RST_CAL1 = 32'h04E2001E;
  localparam logic [31:0] RST_ADC = 32'h00080000;
  localparam logic [31:0] RST_THC0 = 32'h9253F01C;
  localparam logic [31:0] RST_THC1 = 32'h44053805;
  localparam logic [31:0] RST_TRNG = 32'h023A02E4;
  localparam logic [31:0] RST_VRNG = 32'h038402E4;
  localparam logic [15:0] RST_TCODE = 16'd638;
  localparam logic [15:0] RST_VCODE = 16'd800;
  localparam logic [9:0] DATA_MAX = 10'h3FF;

  typedef enum logic [1:0] {
    ACT_READ = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_SAMPLE = 2'd2,
    ACT_NOP = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    RM_REFRESH = 2'd0,
    RM_MONITOR = 2'd1,
    RM_IDLE = 2'd2
  } run_mode_t;

  // mode field of control word 0
  typedef enum logic [1:0] {
    CM_TEMP = 2'd0,
    CM_VOLT = 2'd1,
    CM_MONITOR = 2'd2,
    CM_CALIB = 2'd3
  } ctrl_mode_t;

  typedef enum logic [3:0] {
    ST_FILL,
    ST_FILLCD,
    ST_IDLE,
    ST_RDWAIT,
    ST_STCLR,
    ST_SWEEP,
    ST_SWEEP2,
    ST_SAMPLE,
    ST_OUT
  } state_t;

  // reset value of a register file word
  function automatic logic [31:0] reset_word(input logic [5:0] idx);
    logic [31:0] v;
    v = '0;
    if (idx == IDX_CTRL1) v = RST_CTRL1;
    else if (idx == IDX_CAL0) v = RST_CAL0;
    else if (idx == IDX_CAL1) v = RST_CAL1;
    else if (idx >= IDX_TRNG0 && idx <= IDX_TRNG7) v = RST_TRNG;
    else if (idx >= IDX_VRNG0 && idx <= IDX_VRNG7) v = RST_VRNG;
    else if (idx == IDX_ADC) v = RST_ADC;
    else if (idx == IDX_THC0) v = RST_THC0;
    else if (idx == IDX_THC1) v = RST_THC1;
    return v;
  endfunction

endpackage

// File: sv/srm_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module srm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// File: sv/sensor_range_monitor_regs_unit.sv
// Top level of the sensor range monitor register block.
// Uses srm_pkg and srm_ram (register file and latched code memory).
//
// One input channel (in_valid/in_ready) carries an item: a bus read, a bus
// write or a raw sample. One output channel (out_valid/out_ready) returns a
// result item per input: read_data and irq_level.
// Items are handled one at a time. The register file (39 words) and the
// latched codes (16 entries) sit in single-port RAMs with registered read.
// A read or a write of an ordinary register goes through a read-wait state
// to the output state, a sample through its two sample phases, and a
// no-operation straight to the output state. A write to control word 1, or
// to control word 0 with bit 31 clear, re-evaluates the sixteen latched codes
// (code read, range read, check and write-back); entering monitor mode first
// clears the eight status words. A write to control word 0 with bit 31 set
// reloads the 64 register words, keeping the codes.
// After reset the block fills 64 register words and 16 codes, then runs one
// re-evaluation, all with in_ready low.
// The result is held in an output register while out_ready is low; a new
// item is accepted only once the result has been taken.
// The IRQ level is a flop updated after samples and control writes.
module sensor_range_monitor_regs_unit
  import srm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [5:0]  reg_index,
  input  logic [31:0] write_data,
  input  logic [2:0]  sensor_index,
  input  logic        sample_kind,
  input  logic [15:0] sample_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_data,
  output logic        irq_level
);

  state_t st, st_next;

  // register file RAM
  logic        rf_we;
  logic [5:0]  rf_addr;
  logic [31:0] rf_wdata, rf_rdata;
  // code RAM: {kind, sensor}
  logic        cd_we;
  logic [3:0]  cd_addr;
  logic [15:0] cd_wdata, cd_rdata;

  srm_ram #(.WIDTH(32), .DEPTH(64)) u_rf (
    .clk(clk), .we(rf_we), .addr(rf_addr), .wdata(rf_wdata), .rdata(rf_rdata));
  srm_ram #(.WIDTH(16), .DEPTH(16)) u_cd (
    .clk(clk), .we(cd_we), .addr(cd_addr), .wdata(cd_wdata), .rdata(cd_rdata));

  // control words and ADC result are kept in flops; reads take them from the flops, not the RAM
  logic [31:0] ctrl0, ctrl1, adc;
  run_mode_t   rmode;
  logic [NUM_SENSORS-1:0] flags;   // per sensor: status flag bits non-zero
  logic        irq;

  // captured item
  action_t     act;
  logic [5:0]  idx;
  logic [31:0] wd;
  logic [SENS_W-1:0] sn;
  logic        kd;
  logic [15:0] val;
  logic [31:0] rd;

  // sequencing
  logic [5:0]  cnt;      // fill, clear and sweep counter
  logic        boot;     // power-up pass: no result at the end of the sweep
  logic        ph;       // sample phase: 0 range read, 1 check and write-back
  logic        sweeping;

  logic [NUM_SENSORS-1:0] en_bits, kind_bits, irq_vec;
  logic ok_mon;
  logic wr_ok;
  logic [4:0] alarm_bit;
  logic [9:0] sat;
  logic [15:0] lo, hi;
  logic below, above;
  logic [31:0] stat_word;
  logic [NUM_SENSORS-1:0] flags_n;
  logic irq_n;

  assign in_ready = (st == ST_IDLE);
  assign out_valid = (st == ST_OUT);
  assign read_data = rd;
  assign irq_level = irq;

  assign en_bits = ctrl1[31:24];
  assign kind_bits = ctrl1[23:16];
  assign alarm_bit = {2'b11, sn};
  // writable words: calibration, the three range banks, thermal config
  assign wr_ok = (idx >= IDX_CAL0 && idx <= IDX_RRNG7) || idx == IDX_THC0
    || idx == IDX_THC1;

  // sample check against range word in rf_rdata
  always_comb begin
    sat = (val > 16'(DATA_MAX)) ? DATA_MAX : val[9:0];
    ok_mon = en_bits[sn] && (kind_bits[sn] == kd);
    if (!kd) begin
      hi = rf_rdata[15:0];
      lo = rf_rdata[31:16];
    end else begin
      hi = rf_rdata[31:16];
      lo = rf_rdata[15:0];
    end
    below = val < lo;
    above = val > hi;
    // temp: below bit 31, above bit 30; volt: above bit 29, below bit 28
    stat_word = {below & !kd, above & !kd, above & kd, below & kd, 18'd0, sat};
  end

  always_comb begin
    flags_n = flags;
    if (st == ST_SAMPLE && ph && rmode == RM_MONITOR && ok_mon)
      flags_n[sn] = below | above;
    irq_vec = en_bits & flags_n
      & ((kind_bits & {NUM_SENSORS{ctrl1[14]}}) | (~kind_bits & {NUM_SENSORS{ctrl1[15]}}));
    irq_n = (rmode == RM_MONITOR) && ctrl1[11] && (|irq_vec);
  end

  // next state and RAM port control
  always_comb begin
    rf_we = 1'b0; rf_addr = idx; rf_wdata = wd;
    cd_we = 1'b0; cd_addr = {kd, sn}; cd_wdata = val;
    st_next = st;
    unique case (st)
      ST_FILL: begin
        rf_we = 1'b1;
        rf_addr = cnt;
        rf_wdata = reset_word(cnt);
        if (cnt == 6'd63) st_next = boot ? ST_FILLCD : ST_OUT;
      end
      ST_FILLCD: begin
        cd_we = 1'b1;
        cd_addr = cnt[3:0];
        cd_wdata = cnt[3] ? RST_VCODE : RST_TCODE;
        if (cnt == 6'd15) st_next = ST_SWEEP;
      end
      ST_IDLE: begin
        // start the register read at once; only a read uses the data
        rf_addr = reg_index;
        if (in_valid) begin
          unique case (action_t'(action))
            ACT_READ, ACT_WRITE: st_next = ST_RDWAIT;
            ACT_SAMPLE: st_next = ST_SAMPLE;
            ACT_NOP: st_next = ST_OUT;
          endcase
        end
      end
      ST_RDWAIT: begin
        rf_we = (act == ACT_WRITE) && wr_ok;
        if (act == ACT_WRITE && idx == IDX_CTRL0) begin
          if (wd[31]) st_next = ST_FILL;
          else if (ctrl_mode_t'(wd[15:14]) == CM_MONITOR) st_next = ST_STCLR;
          else st_next = ST_SWEEP;
        end else if (act == ACT_WRITE && idx == IDX_CTRL1) begin
          st_next = ST_SWEEP;
        end else begin
          st_next = ST_OUT;
        end
      end
      ST_STCLR: begin
        // monitor entry: clear the status words
        rf_we = 1'b1;
        rf_addr = IDX_STAT_LO + cnt;
        rf_wdata = '0;
        if (cnt == 6'd7) st_next = ST_SWEEP;
      end
      ST_SWEEP: begin
        // issue code read for next sweep entry
        cd_addr = {cnt[0], cnt[3:1]};
        if (cnt == 6'd16) st_next = boot ? ST_IDLE : ST_OUT;
        else st_next = ST_SWEEP2;
      end
      ST_SWEEP2: st_next = ST_SAMPLE;
      ST_SAMPLE: begin
        if (!ph) begin
          // latch the code of a real sample, read the range word
          cd_we = !sweeping;
          rf_addr = kd ? (IDX_VRNG0 + {3'd0, sn}) : (IDX_TRNG0 + {3'd0, sn});
        end else begin
          rf_addr = IDX_STAT_LO + {3'd0, sn};
          rf_wdata = stat_word;
          rf_we = (rmode == RM_MONITOR) && ok_mon;
          st_next = sweeping ? ST_SWEEP : ST_OUT;
        end
      end
      ST_OUT: if (out_ready) st_next = ST_IDLE;
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) st <= ST_FILL;
    else st <= st_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      boot <= 1'b1;
      ph <= 1'b0;
      sweeping <= 1'b0;
      ctrl0 <= '0;
      ctrl1 <= RST_CTRL1;
      adc <= RST_ADC;
      rmode <= RM_REFRESH;
      flags <= '0;
      irq <= 1'b0;
      rd <= '0;
      act <= ACT_NOP;
      idx <= '0; wd <= '0; sn <= '0; kd <= 1'b0; val <= '0;
    end else begin
      unique case (st)
        ST_FILL: cnt <= cnt + 6'd1;
        ST_FILLCD: begin
          if (cnt == 6'd15) begin
            cnt <= '0;
            sweeping <= 1'b1;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            act <= action_t'(action); idx <= reg_index; wd <= write_data;
            sn <= sensor_index; kd <= sample_kind; val <= sample_value;
            rd <= '0;
            ph <= 1'b0;
            sweeping <= 1'b0;
          end
        end
        ST_RDWAIT: begin
          cnt <= '0;
          if (act == ACT_READ) begin
            if (idx == IDX_CTRL0) rd <= ctrl0;
            else if (idx == IDX_CTRL1) rd <= ctrl1;
            else if (idx == IDX_ADC) rd <= adc;
            else if (idx <= IDX_LAST) rd <= rf_rdata;
            else rd <= '0;
          end else if (idx == IDX_CTRL0) begin
            if (wd[31]) begin
              // soft reset: registers back to reset values, codes kept
              ctrl0 <= '0; ctrl1 <= RST_CTRL1; adc <= RST_ADC;
              rmode <= RM_REFRESH; flags <= '0; irq <= 1'b0;
            end else begin
              ctrl0 <= wd;
              unique case (ctrl_mode_t'(wd[15:14]))
                CM_TEMP, CM_VOLT: rmode <= RM_REFRESH;
                CM_MONITOR: begin
                  rmode <= RM_MONITOR;
                  flags <= '0;
                end
                CM_CALIB: rmode <= RM_IDLE;
              endcase
              sweeping <= 1'b1;
            end
          end else if (idx == IDX_CTRL1) begin
            ctrl1 <= wd;
            sweeping <= 1'b1;
          end
        end
        ST_STCLR: begin
          if (cnt == 6'd7) cnt <= '0;
          else cnt <= cnt + 6'd1;
        end
        ST_SWEEP: begin
          if (cnt == 6'd16) begin
            irq <= irq_n;
            sweeping <= 1'b0;
            boot <= 1'b0;
          end
        end
        ST_SWEEP2: begin
          // code read data arrives now; entry order is temp n, volt n
          val <= cd_rdata;
          sn <= cnt[3:1];
          kd <= cnt[0];
          cnt <= cnt + 6'd1;
          ph <= 1'b0;
        end
        ST_SAMPLE: begin
          if (!ph) begin
            // range word read in flight
            ph <= 1'b1;
          end else begin
            if (rmode == RM_REFRESH && ctrl0[15:14] == {1'b0, kd} && sn == ctrl0[2:0])
              adc[9:0] <= sat;
            if (rmode == RM_MONITOR && ok_mon)
              adc[alarm_bit] <= below | above;
            flags <= flags_n;
            irq <= irq_n;
            ph <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
